// ===== src/ibmw_pkg.sv =====
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared types and constants of the indirect block map walker: item and
// result layouts, command codes and the stage-one record.
// ----------------------------------------------------------------------------
package ibmw_pkg;

    localparam int WORD_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int BSL_W      = 2;
    // Pointers per block are 2^(BASE_SHIFT + block_size_log).
    localparam int BASE_SHIFT = 8;
    // Block size in bytes is 2^(SIZE_SHIFT + block_size_log).
    localparam int SIZE_SHIFT = 10;
    // A word index inside one pointer block is below the largest pointer count.
    localparam int WIDX_W     = BASE_SHIFT + 3;
    // Level capacities reach 2^33, so level arithmetic runs a little wider.
    localparam int CAP_W      = 36;
    localparam int SHAMT_W    = 6;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_MAP      = 2'd1;
    localparam logic [1:0] CMD_READBACK = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic [SLOT_W-1:0] pointer_slot;
        logic [WORD_W-1:0] word_value;
        logic [WORD_W-1:0] logical_block;
    } t_item;

    typedef struct packed {
        logic              result_kind;
        logic [WORD_W-1:0] read_address;
        logic [WORD_W-1:0] physical_block;
    } t_result;

    typedef enum logic [2:0] {
        S1_NOP,
        S1_DIRECT,
        S1_HOLE,
        S1_WALK,
        S1_READBACK
    } t_s1_op;

    // What stage one needs to finish an item; the table word arrives
    // separately from the memory.
    typedef struct packed {
        t_s1_op            op;
        logic [WORD_W-1:0] word_value;
        logic [1:0]        depth;
        logic [WIDX_W-1:0] widx;
        logic [WORD_W-1:0] rem;
    } t_s1;

endpackage

// ===== src/ibmw_ptr_table.sv =====
// ----------------------------------------------------------------------------
// ibmw_ptr_table
// Inode pointer table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ibmw_ptr_table #(
    parameter int DEPTH = 15,
    parameter int AW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [ibmw_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [ibmw_pkg::WORD_W-1:0] o_rd_data
);
    import ibmw_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ibmw_level_sel.sv =====
// ----------------------------------------------------------------------------
// ibmw_level_sel
// Front stage: decodes an accepted item, drives the table ports, picks the
// indirection level of a map request and registers the stage-one record.
// ----------------------------------------------------------------------------
module ibmw_level_sel #(
    parameter int DIRECT_COUNT = 12,
    parameter int MAX_LEVELS   = 3,
    parameter int AW           = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  ibmw_pkg::t_item            i_item,
    input  logic [ibmw_pkg::BSL_W-1:0] i_bsl,
    input  logic                       i_s1_done,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    output logic                       o_s1_valid,
    output ibmw_pkg::t_s1              o_s1
);
    import ibmw_pkg::*;

    localparam int TABLE_SIZE = DIRECT_COUNT + MAX_LEVELS;

    logic [3:0]         sh;
    logic [WORD_W-1:0]  b;
    logic [CAP_W-1:0]   base [MAX_LEVELS];
    logic [CAP_W-1:0]   cap  [MAX_LEVELS];
    logic [CAP_W-1:0]   diff [MAX_LEVELS];
    logic               found;
    logic [1:0]         sel;
    logic [WORD_W-1:0]  idx;
    logic [SHAMT_W-1:0] dsh;
    logic               is_direct;
    t_s1                n_s1;
    logic               n_s1_valid;
    logic               r_s1_valid;
    t_s1                r_s1;

    assign sh        = 4'(BASE_SHIFT) + 4'(i_bsl);
    assign b         = i_item.logical_block - WORD_W'(DIRECT_COUNT);
    assign is_direct = i_item.logical_block < WORD_W'(DIRECT_COUNT);

    // Level k covers the next P^(k+1) blocks after the levels below it.
    // The offsets are sums of distinct powers of two, so an OR builds them.
    always_comb begin
        base[0] = '0;
        for (int l = 1; l < MAX_LEVELS; l++) begin
            base[l] = base[l-1] | (CAP_W'(1) << (l * int'(sh)));
        end
        for (int l = 0; l < MAX_LEVELS; l++) begin
            cap[l]  = CAP_W'(1) << ((l + 1) * int'(sh));
            diff[l] = CAP_W'(b) - base[l];
        end
    end

    // A block below a level's offset wraps to a huge difference and fails.
    always_comb begin
        found = 1'b0;
        sel   = '0;
        idx   = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (!found && (diff[l] < cap[l])) begin
                found = 1'b1;
                sel   = 2'(l);
                idx   = diff[l][WORD_W-1:0];
            end
        end
    end

    assign dsh = SHAMT_W'(sel) * SHAMT_W'(sh);

    always_comb begin
        n_s1            = '0;
        n_s1.op         = S1_NOP;
        n_s1.word_value = i_item.word_value;
        case (i_item.command)
            CMD_MAP: begin
                if (is_direct) begin
                    n_s1.op = S1_DIRECT;
                end else if (found) begin
                    n_s1.op    = S1_WALK;
                    n_s1.depth = sel;
                    n_s1.widx  = WIDX_W'(idx >> dsh);
                    n_s1.rem   = idx & WORD_W'((33'(1) << dsh) - 33'(1));
                end else begin
                    n_s1.op = S1_HOLE;
                end
            end
            CMD_READBACK: begin
                n_s1.op = S1_READBACK;
            end
            default: begin
                n_s1.op = S1_NOP;
            end
        endcase
    end

    assign o_wr_en   = i_accept && (i_item.command == CMD_LOAD)
                       && (int'(i_item.pointer_slot) < TABLE_SIZE);
    assign o_wr_addr = AW'(i_item.pointer_slot);
    assign o_rd_en   = i_accept && (i_item.command == CMD_MAP)
                       && (is_direct || found);
    assign o_rd_addr = is_direct ? AW'(i_item.logical_block)
                                 : (AW'(DIRECT_COUNT) + AW'(sel));

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (i_s1_done) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// ===== src/ibmw_walk_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibmw_walk_ctrl
// Back stage: holds the walk state, forms read requests and final mappings
// from the table word or the returned pointer word, and owns the output
// register.
// ----------------------------------------------------------------------------
module ibmw_walk_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  ibmw_pkg::t_s1               i_s1,
    input  logic [ibmw_pkg::WORD_W-1:0] i_rd_data,
    input  logic [ibmw_pkg::BSL_W-1:0]  i_bsl,
    input  logic                        i_out_ready,
    output logic                        o_s1_done,
    output logic                        o_out_valid,
    output ibmw_pkg::t_result           o_out_item
);
    import ibmw_pkg::*;

    logic               r_busy;
    logic [1:0]         r_levels;
    logic [WORD_W-1:0]  r_rem;
    logic               n_busy;
    logic [1:0]         n_levels;
    logic [WORD_W-1:0]  n_rem;
    logic               r_out_valid;
    t_result            r_out;
    t_result            res;
    logic               has_result;
    logic               out_free;
    logic [3:0]         sh;
    logic [3:0]         sz;
    logic [1:0]         d;
    logic [SHAMT_W-1:0] dsh;

    assign sh  = 4'(BASE_SHIFT) + 4'(i_bsl);
    assign sz  = 4'(SIZE_SHIFT) + 4'(i_bsl);
    assign d   = r_levels - 2'd1;
    assign dsh = SHAMT_W'(d) * SHAMT_W'(sh);

    always_comb begin
        n_busy     = r_busy;
        n_levels   = r_levels;
        n_rem      = r_rem;
        res        = '0;
        has_result = 1'b0;
        case (i_s1.op)
            S1_DIRECT: begin
                has_result         = 1'b1;
                res.result_kind    = KIND_FINAL;
                res.physical_block = i_rd_data;
                n_busy             = 1'b0;
                n_levels           = '0;
                n_rem              = '0;
            end
            S1_HOLE: begin
                has_result      = 1'b1;
                res.result_kind = KIND_FINAL;
                n_busy          = 1'b0;
                n_levels        = '0;
                n_rem           = '0;
            end
            S1_WALK: begin
                has_result = 1'b1;
                if (i_rd_data == '0) begin
                    res.result_kind = KIND_FINAL;
                    n_busy          = 1'b0;
                    n_levels        = '0;
                    n_rem           = '0;
                end else begin
                    res.result_kind  = KIND_READ;
                    res.read_address = (i_rd_data << sz)
                                       + WORD_W'({i_s1.widx, 2'b00});
                    n_busy           = 1'b1;
                    n_levels         = i_s1.depth;
                    n_rem            = i_s1.rem;
                end
            end
            S1_READBACK: begin
                if (r_busy) begin
                    has_result = 1'b1;
                    if ((r_levels == '0) || (i_s1.word_value == '0)) begin
                        res.result_kind    = KIND_FINAL;
                        res.physical_block = i_s1.word_value;
                        n_busy             = 1'b0;
                        n_levels           = '0;
                        n_rem              = '0;
                    end else begin
                        // Descend one level: the upper digits of the index
                        // pick the word, the rest stays for the levels below.
                        res.result_kind  = KIND_READ;
                        res.read_address = (i_s1.word_value << sz)
                                           + ((r_rem >> dsh) << 2);
                        n_levels         = d;
                        n_rem            = r_rem
                                           & WORD_W'((33'(1) << dsh) - 33'(1));
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_s1_done = i_s1_valid && (!has_result || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_levels    <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s1_done) begin
                r_busy   <= n_busy;
                r_levels <= n_levels;
                r_rem    <= n_rem;
            end
            if (o_s1_done && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_s1_done && has_result) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== src/indirect_block_map_walker.sv =====
// ----------------------------------------------------------------------------
// indirect_block_map_walker
// Maps a file's logical block number to a physical block through an inode
// pointer table of direct and indirect pointers.
// ----------------------------------------------------------------------------
// Usage:
// Input items (valid/ready) carry a command: load a table pointer, map a
// logical block, or return a pointer word that the block asked for.
// Output items (valid/ready) are either a read request for a pointer word
// (byte address) or a final mapping, where block 0 stands for a hole.
// A map below the direct count answers from the table; a deeper map emits
// one read request per indirection level, each answered by a read-back item.
// A new map abandons any walk in progress.
// An accepted item and its table read are registered in the front stage;
// the back stage forms the result from them into the output register.
// One item is accepted every cycle unless an output stall holds stage one;
// a map does one table read in front, a read request one address add behind.
// Loads and ignored items give no output transfer.
// The block size register must be written through i_cfg_we only while idle;
// the block itself does not enforce this. Reset clears the walk state, the
// pipeline and the block size code; the pointer table holds nothing valid until loaded.
// When the receiver stalls, the output register holds its transfer and one
// more item may wait in the stage-one record register; then o_in_ready falls.
// ----------------------------------------------------------------------------
module indirect_block_map_walker #(
    parameter int DIRECT_COUNT = 12,
    parameter int MAX_LEVELS   = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ibmw_pkg::t_item            i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ibmw_pkg::t_result          o_out_item,
    input  logic                       i_cfg_we,
    input  logic [ibmw_pkg::BSL_W-1:0] i_cfg_wdata
);
    import ibmw_pkg::*;

    localparam int TABLE_SIZE = DIRECT_COUNT + MAX_LEVELS;
    localparam int AW         = $clog2(TABLE_SIZE);

    logic [BSL_W-1:0]  r_bsl;
    logic              accept;
    logic              s1_valid;
    t_s1               s1;
    logic              s1_done;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl <= '0;
        end else if (i_cfg_we) begin
            r_bsl <= i_cfg_wdata;
        end
    end

    assign o_in_ready = !s1_valid || s1_done;
    assign accept     = i_in_valid && o_in_ready;

    ibmw_level_sel #(
        .DIRECT_COUNT (DIRECT_COUNT),
        .MAX_LEVELS   (MAX_LEVELS),
        .AW           (AW)
    ) u_level_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_bsl      (r_bsl),
        .i_s1_done  (s1_done),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    ibmw_ptr_table #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_ptr_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_item.word_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ibmw_walk_ctrl u_walk_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_rd_data   (rd_data),
        .i_bsl       (r_bsl),
        .i_out_ready (i_out_ready),
        .o_s1_done   (s1_done),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
